// File: sv/ljeo_pkg.sv
`default_nettype none
package ljeo_pkg;
  localparam int RotSteps = 16;
  localparam logic signed [19:0] RotGain = 20'sd39797;
  localparam logic signed [19:0] UnitQ16 = 20'sd65536;

  localparam logic [2:0] RegAngleStart = 3'd0;
  localparam logic [2:0] RegAngleStep  = 3'd1;
  localparam logic [2:0] RegMaxRange   = 3'd2;
  localparam logic [2:0] RegJumpThr    = 3'd3;
  localparam logic [2:0] RegMaxDiam    = 3'd4;
  localparam logic [2:0] RegMinRange   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_PREP,
    ST_ROT_RUN,
    ST_ROT_DONE,
    ST_CHORD_A,
    ST_CHORD_B,
    ST_CHORD_C,
    ST_SQRT,
    ST_DECIDE,
    ST_MID,
    ST_MID_ACC
  } ljeo_state_t;

  typedef struct packed {
    logic start;
    logic [15:0] angle;
  } rot_req_t;

  typedef struct packed {
    logic done;
    logic signed [17:0] cos_v;
    logic signed [17:0] sin_v;
  } rot_rsp_t;

  function automatic logic [15:0] arc_tab(input logic [3:0] k);
    case (k)
      4'd0: arc_tab = 16'd8192;
      4'd1: arc_tab = 16'd4836;
      4'd2: arc_tab = 16'd2555;
      4'd3: arc_tab = 16'd1297;
      4'd4: arc_tab = 16'd651;
      4'd5: arc_tab = 16'd326;
      4'd6: arc_tab = 16'd163;
      4'd7: arc_tab = 16'd81;
      4'd8: arc_tab = 16'd41;
      4'd9: arc_tab = 16'd20;
      4'd10: arc_tab = 16'd10;
      4'd11: arc_tab = 16'd5;
      4'd12: arc_tab = 16'd3;
      4'd13: arc_tab = 16'd1;
      4'd14: arc_tab = 16'd1;
      default: arc_tab = 16'd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// File: sv/ljeo_if.sv
`default_nettype none
interface ljeo_in_if;
  logic valid;
  logic ready;
  logic [15:0] range_sample;
  logic scan_start;
  modport source (output valid, output range_sample, output scan_start, input ready);
  modport sink (input valid, input range_sample, input scan_start, output ready);
endinterface

interface ljeo_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [15:0] object_width;
  modport source (output valid, output center_x, output center_y, output object_width,
    input ready);
  modport sink (input valid, input center_x, input center_y, input object_width,
    output ready);
endinterface
`default_nettype wire

// File: sv/ljeo_cordic.sv
`default_nettype none
module ljeo_cordic (
  input  wire logic clk,
  input  wire logic rst,
  input  wire ljeo_pkg::rot_req_t req,
  output ljeo_pkg::rot_rsp_t rsp
);
  import ljeo_pkg::*;

  logic signed [19:0] x, y, z;
  logic [1:0] quad;
  logic [3:0] k;
  logic busy;
  logic done;
  logic signed [19:0] dx, dy, xc, yc;

  // arithmetic shift floors toward minus infinity
  assign dx = y >>> k;
  assign dy = x >>> k;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        k <= 4'd0;
        x <= RotGain;
        y <= 20'sd0;
        z <= {6'd0, req.angle[13:0]};
        quad <= req.angle[15:14];
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - $signed({4'd0, arc_tab(k)});
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + $signed({4'd0, arc_tab(k)});
        end
        k <= k + 4'd1;
        if (k == 4'(RotSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    xc = (x > UnitQ16) ? UnitQ16 : ((x < -UnitQ16) ? -UnitQ16 : x);
    yc = (y > UnitQ16) ? UnitQ16 : ((y < -UnitQ16) ? -UnitQ16 : y);
    rsp.done = done;
    case (quad)
      2'd0: begin rsp.cos_v = xc[17:0]; rsp.sin_v = yc[17:0]; end
      2'd1: begin rsp.cos_v = -yc[17:0]; rsp.sin_v = xc[17:0]; end
      2'd2: begin rsp.cos_v = -xc[17:0]; rsp.sin_v = -yc[17:0]; end
      default: begin rsp.cos_v = yc[17:0]; rsp.sin_v = -xc[17:0]; end
    endcase
  end
endmodule
`default_nettype wire

// File: sv/ljeo_isqrt.sv
`default_nettype none
module ljeo_isqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [33:0] value,
  output logic done,
  output logic [16:0] root
);
  // restoring square root, one result bit per cycle
  logic [33:0] rem;
  logic [16:0] res;
  logic [4:0] n;
  logic busy;
  logic [35:0] trial;
  logic [35:0] rem_sh;

  assign rem_sh = {2'b00, rem[31:0], 2'b00} | {34'd0, value[2*n+:2]};
  assign trial = {17'd0, res, 2'b01};
  assign root = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem <= 34'd0;
        res <= 17'd0;
        n <= 5'd16;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem <= 34'(rem_sh - trial);
          res <= {res[15:0], 1'b1};
        end else begin
          rem <= rem_sh[33:0];
          res <= {res[15:0], 1'b0};
        end
        if (n == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          n <= n - 5'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/lidar_jump_edge_object_extractor.sv
`default_nettype none
// lidar jump-edge object extractor
// in: one range sample item per handshake (range_sample, scan_start)
// out: one object item (center_x, center_y, object_width) when a tracked
//   object closes on a rising range step
// cfg: apb write/read port, registers at byte addresses 4*i
// a scan-start item or a searching item is taken while idle and the next
//   item can follow at once
// a tracking item keeps the block busy after it is taken: a cordic run for
//   the chord angle (with start and capture), the chord states A to C, the
//   square root and a decision state; only then is the next item taken
// a closing item adds two cordic runs, for the open and the previous angle, and
//   the states ST_MID and ST_MID_ACC; the next item is taken once its result is loaded
// in.ready is high only while the sequencer idles
// the result waits in an output register until out.ready; a stalled receiver
//   holds the block only when the next result is ready to be loaded
// reset restores the register defaults and starts in the searching state
//   with previous range 10240 and sample index zero
module lidar_jump_edge_object_extractor #(
  parameter int MAX_SAMPLES = 4096
) (
  input  wire logic clk,
  input  wire logic rst,
  ljeo_in_if.sink in,
  ljeo_out_if.source out,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [4:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import ljeo_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);

  logic [15:0] angle_start;
  logic [12:0] angle_step;
  logic [15:0] max_range, jump_threshold, diam_limit, min_range;

  logic [15:0] previous_range, open_range, cur;
  logic [IW-1:0] sample_count, open_index, prev_idx, cur_idx, next_idx;
  logic searching;

  ljeo_state_t state, state_next;
  rot_req_t rot_req;
  rot_rsp_t rot_rsp;
  logic sq_start, sq_done;
  logic [16:0] sq_root;

  logic [15:0] th_open, th_prev;
  logic [15:0] cur_r;
  logic [1:0] phase;
  logic signed [17:0] c_open, s_open;
  logic signed [17:0] cosd;
  logic signed [17:0] s_prev;
  logic [15:0] prev_r_hold;
  logic [31:0] pa, pb;
  logic [32:0] ab;
  logic signed [50:0] d_acc;
  logic [33:0] q_val;
  logic [16:0] span;
  logic signed [35:0] mx, my;
  logic signed [15:0] cx_r, cy_r;
  logic [15:0] w_r;
  logic out_valid;
  logic out_free;
  logic [IW-1:0] th_idx;
  logic [15:0] th_val;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= 16'd0;
      angle_step <= 13'd46;
      max_range <= 16'd10240;
      jump_threshold <= 16'd768;
      diam_limit <= 16'd512;
      min_range <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        RegAngleStart: angle_start <= pwdata[15:0];
        RegAngleStep: angle_step <= pwdata[12:0];
        RegMaxRange: max_range <= pwdata[15:0];
        RegJumpThr: jump_threshold <= pwdata[15:0];
        RegMaxDiam: diam_limit <= pwdata[15:0];
        RegMinRange: min_range <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegAngleStart: prdata = {16'd0, angle_start};
      RegAngleStep: prdata = {19'd0, angle_step};
      RegMaxRange: prdata = {16'd0, max_range};
      RegJumpThr: prdata = {16'd0, jump_threshold};
      RegMaxDiam: prdata = {16'd0, diam_limit};
      RegMinRange: prdata = {16'd0, min_range};
      default: prdata = 32'd0;
    endcase
  end

  assign cur = (in.range_sample == 16'd0 || in.range_sample > max_range)
               ? max_range : in.range_sample;
  assign cur_idx = sample_count;
  // sample indices wrap at MAX_SAMPLES
  assign prev_idx = (sample_count == '0) ? IW'(MAX_SAMPLES - 1) : sample_count - IW'(1);
  assign next_idx = (sample_count == IW'(MAX_SAMPLES - 1)) ? '0 : sample_count + IW'(1);

  // one IWx13 multiply per angle, only low 16 bits matter
  assign th_val = angle_start + 16'(32'(th_idx) * 32'(angle_step));

  ljeo_cordic u_rot (.clk(clk), .rst(rst), .req(rot_req), .rsp(rot_rsp));
  ljeo_isqrt u_sqrt (.clk(clk), .rst(rst), .start(sq_start), .value(q_val),
    .done(sq_done), .root(sq_root));

  assign in.ready = (state == ST_IDLE);
  assign out.valid = out_valid;
  assign out.center_x = cx_r;
  assign out.center_y = cy_r;
  assign out.object_width = w_r;
  assign out_free = !out_valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    rot_req.start = 1'b0;
    rot_req.angle = th_open - th_prev;
    sq_start = 1'b0;
    th_idx = open_index;
    case (state)
      ST_IDLE: if (in.valid && !in.scan_start && !searching) state_next = ST_ROT_PREP;
      ST_ROT_PREP: begin
        rot_req.start = 1'b1;
        case (phase)
          2'd1: rot_req.angle = th_open;
          2'd2: rot_req.angle = th_prev;
          default: rot_req.angle = th_open - th_prev;
        endcase
        state_next = ST_ROT_RUN;
      end
      ST_ROT_RUN: if (rot_rsp.done) state_next = ST_ROT_DONE;
      ST_ROT_DONE: begin
        case (phase)
          2'd0: state_next = ST_CHORD_A;
          2'd1: state_next = ST_ROT_PREP;
          default: state_next = ST_MID;
        endcase
      end
      ST_CHORD_A: state_next = ST_CHORD_B;
      ST_CHORD_B: state_next = ST_CHORD_C;
      ST_CHORD_C: begin
        sq_start = 1'b1;
        state_next = ST_SQRT;
      end
      ST_SQRT: if (sq_done) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if ({15'd0, span} > {16'd0, diam_limit} || previous_range < min_range)
          state_next = ST_IDLE;
        else if ({1'b0, cur_r} > {1'b0, previous_range} + {1'b0, jump_threshold})
          state_next = ST_ROT_PREP;
        else state_next = ST_IDLE;
      end
      ST_MID: state_next = ST_MID_ACC;
      ST_MID_ACC: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin : dp
    logic signed [36:0] sx, sy;
    if (rst) begin
      previous_range <= 16'd10240;
      sample_count <= '0;
      searching <= 1'b1;
      open_index <= '0;
      open_range <= 16'd0;
      out_valid <= 1'b0;
      phase <= 2'd0;
    end else begin
      if (out_valid && out.ready && state != ST_MID_ACC) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in.valid) begin
            cur_r <= cur;
            phase <= 2'd0;
            if (in.scan_start) begin
              searching <= 1'b1;
              previous_range <= cur;
              sample_count <= IW'(1);
            end else if (searching) begin
              if ({1'b0, previous_range} > {1'b0, cur} + {1'b0, jump_threshold}) begin
                open_index <= cur_idx;
                open_range <= cur;
                searching <= 1'b0;
              end
              previous_range <= cur;
              sample_count <= next_idx;
            end else begin
              th_prev <= angle_start + 16'(32'(prev_idx) * 32'(angle_step));
              th_open <= th_val;
            end
          end
        end
        ST_ROT_DONE: begin
          if (phase == 2'd0) cosd <= rot_rsp.cos_v;
          if (phase == 2'd1) begin
            c_open <= rot_rsp.cos_v;
            s_open <= rot_rsp.sin_v;
          end
          if (phase != 2'd0) phase <= phase + 2'd1;
        end
        ST_CHORD_A: begin
          pa <= 32'(open_range) * 32'(open_range);
          pb <= 32'(previous_range) * 32'(previous_range);
          ab <= {1'b0, 32'(open_range) * 32'(previous_range)};
        end
        ST_CHORD_B: begin
          d_acc <= $signed({2'b00, {1'b0, pa} + {1'b0, pb}, 16'd0})
                   - ($signed({17'd0, ab, 1'b0}) * cosd);
        end
        ST_CHORD_C: begin
          if (d_acc < 0) q_val <= 34'd0;
          else q_val <= 34'((d_acc + 51'sd32768) >>> 16);
        end
        ST_DECIDE: begin
          span <= span;
          if ({15'd0, span} > {16'd0, diam_limit} || previous_range < min_range) begin
            searching <= 1'b1;
          end else if ({1'b0, cur_r} > {1'b0, previous_range} + {1'b0, jump_threshold}) begin
            phase <= 2'd1;
          end
          if (!({15'd0, span} > {16'd0, diam_limit} || previous_range < min_range)
              && {1'b0, cur_r} > {1'b0, previous_range} + {1'b0, jump_threshold})
            searching <= 1'b1;
          previous_range <= cur_r;
          sample_count <= next_idx;
        end
        ST_MID: begin
          mx <= $signed({1'b0, open_range}) * c_open;
          my <= $signed({1'b0, open_range}) * s_open;
        end
        ST_MID_ACC: begin
          // prev range was latched into prev_r_hold; previous_range now holds the sample from cur_r
          sx = 37'(mx) + 37'($signed({1'b0, prev_r_hold}) * cosd) + 37'sd65536;
          sy = 37'(my) + 37'($signed({1'b0, prev_r_hold}) * s_prev) + 37'sd65536;
          sx = sx >>> 17;
          sy = sy >>> 17;
          // load only once the previous item has left the output register
          if (out_free) begin
            cx_r <= (sx > 37'sd32767) ? 16'sh7FFF
                    : ((sx < -37'sd32768) ? 16'sh8000 : sx[15:0]);
            cy_r <= (sy > 37'sd32767) ? 16'sh7FFF
                    : ((sy < -37'sd32768) ? 16'sh8000 : sy[15:0]);
            w_r <= span[16] ? 16'hFFFF : span[15:0];
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      if (state == ST_SQRT && sq_done) span <= sq_root;
      if (state == ST_ROT_DONE && phase == 2'd2) begin
        cosd <= rot_rsp.cos_v;
        s_prev <= rot_rsp.sin_v;
      end
      if (state == ST_DECIDE) prev_r_hold <= previous_range;
    end
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in.ready) else $error("ready while busy");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_MID_ACC && out_free |=> out_valid) else $error("result not loaded");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: tb/lidar_jump_edge_object_extractor_test.sv
`timescale 1ns / 100ps
`default_nettype none
module lidar_jump_edge_object_extractor_test;
  import ljeo_pkg::*;

  localparam longint ArcQ[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                  41, 20, 10, 5, 3, 1, 1, 0};

  typedef struct {
    logic [15:0] range_sample;
    logic scan_start;
  } sample_t;

  typedef struct {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0] object_width;
  } object_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ljeo_in_if in_ch();
  ljeo_out_if out_ch();

  lidar_jump_edge_object_extractor DUT (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  sample_t sample_q[$];
  object_t object_q[$];
  int failures = 0;
  bit in_taken = 0;
  bit calm = 0;
  bit hold_out = 0;

  // shadow registers and scanner state
  logic [15:0] sh_angle_start, sh_max_range, sh_jump, sh_max_diam, sh_min_range;
  logic [12:0] sh_angle_step;
  logic [15:0] prev_range, open_range;
  logic [11:0] next_index, open_index;
  bit hunting;

  function automatic void trig(input logic [15:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = 39797;
    y = 0;
    z = ang[13:0];
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcQ[k];
      end else begin
        x += dx; y -= dy; z += ArcQ[k];
      end
    end
    if (x > 65536) x = 65536;
    if (x < -65536) x = -65536;
    if (y > 65536) y = 65536;
    if (y < -65536) y = -65536;
    case (ang[15:14])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned chord_len(input longint a, input longint b,
                                                input logic [15:0] delta);
    longint c, s, d;
    trig(delta, c, s);
    d = ((a * a + b * b) <<< 16) - 2 * a * b * c;
    if (d < 0) d = 0;
    return int_sqrt((longint'(d) + 32768) >> 16);
  endfunction

  function automatic logic signed [15:0] midpoint(input longint r1, input longint t1,
                                                  input longint r2, input longint t2);
    longint m;
    m = (r1 * t1 + r2 * t2 + 65536) >>> 17;
    if (m > 32767) m = 32767;
    if (m < -32768) m = -32768;
    return m[15:0];
  endfunction

  function automatic logic [15:0] theta(input logic [11:0] idx);
    return sh_angle_start + 16'(32'(sh_angle_step) * 32'(idx));
  endfunction

  function automatic void scan_step(input sample_t it);
    logic [15:0] cur, th_open, th_prev;
    logic [11:0] prev_idx;
    longint unsigned span;
    longint c1, s1, c2, s2;
    object_t ob;
    cur = (it.range_sample == 0 || it.range_sample > sh_max_range) ? sh_max_range
                                                                   : it.range_sample;
    if (it.scan_start) begin
      hunting = 1;
      prev_range = cur;
      next_index = 12'd1;
      return;
    end
    prev_idx = next_index - 12'd1;
    if (hunting) begin
      if (32'(prev_range) > 32'(cur) + 32'(sh_jump)) begin
        open_index = next_index;
        open_range = cur;
        hunting = 0;
      end
    end else begin
      th_open = theta(open_index);
      th_prev = theta(prev_idx);
      span = chord_len(open_range, prev_range, th_open - th_prev);
      if (span > sh_max_diam || prev_range < sh_min_range) begin
        hunting = 1;
      end else if (32'(cur) > 32'(prev_range) + 32'(sh_jump)) begin
        trig(th_open, c1, s1);
        trig(th_prev, c2, s2);
        ob.center_x = midpoint(open_range, c1, prev_range, c2);
        ob.center_y = midpoint(open_range, s1, prev_range, s2);
        ob.object_width = span > 65535 ? 16'hFFFF : span[15:0];
        object_q.insert(object_q.size(), ob);
        hunting = 1;
      end
    end
    prev_range = cur;
    next_index = next_index + 12'd1;
  endfunction

  // input side
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (in_taken) scan_step('{in_ch.range_sample, in_ch.scan_start});
  end

  always @(negedge clk) begin
    sample_t s;
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.range_sample <= 0;
      in_ch.scan_start <= 0;
    end else if (!in_ch.valid || in_taken) begin
      if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        s = sample_q.pop_front();
        in_ch.valid <= 1;
        in_ch.range_sample <= s.range_sample;
        in_ch.scan_start <= s.scan_start;
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // output side
  always @(negedge clk)
    out_ch.ready <= !hold_out && (calm || $urandom_range(99) >= 36);

  always @(posedge clk) begin
    object_t ob;
    if (out_ch.valid && out_ch.ready) begin
      if (object_q.size() == 0) begin
        $display("%0t: unexpected object x=%0d y=%0d w=%0d", $time, out_ch.center_x,
                 out_ch.center_y, out_ch.object_width);
        failures++;
      end else begin
        ob = object_q.pop_front();
        if (ob.center_x !== out_ch.center_x) begin
          $display("%0t: center_x expected %0d got %0d", $time, ob.center_x, out_ch.center_x);
          failures++;
        end
        if (ob.center_y !== out_ch.center_y) begin
          $display("%0t: center_y expected %0d got %0d", $time, ob.center_y, out_ch.center_y);
          failures++;
        end
        if (ob.object_width !== out_ch.object_width) begin
          $display("%0t: object_width expected %0d got %0d", $time, ob.object_width,
                   out_ch.object_width);
          failures++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegAngleStart: sh_angle_start = val[15:0];
      RegAngleStep:  sh_angle_step = val[12:0];
      RegMaxRange:   sh_max_range = val[15:0];
      RegJumpThr:    sh_jump = val[15:0];
      RegMaxDiam:    sh_max_diam = val[15:0];
      RegMinRange:   sh_min_range = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !in_ch.valid && object_q.size() == 0);
    repeat (100) @(negedge clk);
  endtask

  task automatic push(input int r, input bit st);
    sample_q.insert(sample_q.size(), '{r[15:0], st});
  endtask

  // well-formed object: background, drop, a few close samples, rise
  task automatic add_object();
    int bg, obj, n, lo;
    lo = (sh_max_range > 0) ? $urandom_range(sh_max_range) : 0;
    obj = $urandom_range(lo, sh_max_range);
    bg = obj + sh_jump + 1 + $urandom_range(40);
    if (bg > sh_max_range) bg = 0;
    push(bg, 0);
    push(obj, 0);
    n = $urandom_range(5);
    repeat (n) push(obj + $urandom_range(8) - 4, 0);
    push(bg, 0);
  endtask

  task automatic random_part(input int count);
    int u;
    repeat (count) begin
      u = $urandom_range(99);
      if (u < 4) push($urandom, 1);
      else if (u < 60) add_object();
      else if (u < 65) push(0, 0);
      else push($urandom, 0);
    end
  endtask

  initial begin
    sh_angle_start = 0; sh_angle_step = 46; sh_max_range = 10240;
    sh_jump = 768; sh_max_diam = 512; sh_min_range = 256;
    prev_range = 10240; next_index = 0; hunting = 1; open_index = 0; open_range = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // no scan start yet: first sample pairs with the reset range
    push(2000, 0); push(2010, 0); push(2005, 0); push(6000, 0);
    push(0, 0); push(16'hFFFF, 0); push(3000, 1); push(1000, 0); push(100, 0);
    push(120, 0); push(9000, 0); push(16'h8001, 0); push(1500, 0); push(1502, 0);
    push(1501, 0); push(5000, 0); push(10240, 0); push(1200, 0); push(8000, 0);
    drain();

    calm = 1;
    random_part(60);
    calm = 0;
    random_part(60);
    drain();

    // long output stall so the block backs up onto its input
    fork
      begin
        hold_out = 1;
        repeat (600) @(negedge clk);
        hold_out = 0;
      end
      random_part(30);
    join
    drain();

    write_reg(RegAngleStart, 32'h8000);
    write_reg(RegAngleStep, 8191);
    write_reg(RegMaxRange, 65535);
    write_reg(RegJumpThr, 0);
    write_reg(RegMaxDiam, 65535);
    write_reg(RegMinRange, 0);
    random_part(50);
    drain();

    write_reg(RegMaxRange, 0);
    random_part(15);
    drain();

    write_reg(RegAngleStart, 32'h7FFF);
    write_reg(RegAngleStep, 0);
    write_reg(RegMaxRange, 65535);
    write_reg(RegJumpThr, 65535);
    write_reg(RegMaxDiam, 0);
    write_reg(RegMinRange, 65535);
    random_part(20);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(RegAngleStart, $urandom);
      write_reg(RegAngleStep, $urandom_range(p < 3 ? 200 : 8191));
      write_reg(RegMaxRange, $urandom_range(2000, 65535));
      write_reg(RegJumpThr, $urandom_range(1500));
      write_reg(RegMaxDiam, $urandom_range(65535));
      write_reg(RegMinRange, $urandom_range(1000));
      random_part(25);
      drain();
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
sv/ljeo_pkg.sv
sv/ljeo_if.sv
sv/ljeo_cordic.sv
sv/ljeo_isqrt.sv
sv/lidar_jump_edge_object_extractor.sv
tb/lidar_jump_edge_object_extractor_test.sv
